// ----- rtl/core/eib_pkg.sv -----
`timescale 1ns / 1ps

package eib_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // pixel word: blue [7:0], green [15:8], red [23:16], alpha [31:24]
    localparam int PIX_W = 32;
    localparam int ACC_W = 12;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic       mem_en;
        logic       mem_we;
        logic       seed;
        logic       calc;
        logic [1:0] ch;
        logic       done;
    } seq_ctrl_t;

    function automatic logic [4:0] pick_weight(input logic [4:0] radius);
        logic [4:0] w;
        begin
            case (radius)
                5'd0:    w = 5'd16;
                5'd1:    w = 5'd14;
                5'd2:    w = 5'd10;
                5'd3:    w = 5'd8;
                5'd4:    w = 5'd6;
                5'd5:    w = 5'd5;
                5'd6:    w = 5'd5;
                5'd7:    w = 5'd4;
                5'd8:    w = 5'd3;
                5'd9:    w = 5'd3;
                5'd10:   w = 5'd3;
                5'd11:   w = 5'd3;
                5'd12:   w = 5'd2;
                5'd13:   w = 5'd2;
                5'd14:   w = 5'd2;
                5'd15:   w = 5'd2;
                5'd16:   w = 5'd2;
                5'd17:   w = 5'd2;
                default: w = 5'd1;
            endcase
            return w;
        end
    endfunction

endpackage

// ----- rtl/core/eib_pixel_ram.sv -----
`timescale 1ns / 1ps

module eib_pixel_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [AW-1:0]            addr,
    input  logic [eib_pkg::PIX_W-1:0] wdata,
    output logic [eib_pkg::PIX_W-1:0] rdata
);

    logic [eib_pkg::PIX_W-1:0] mem [0:DEPTH-1];
    logic [eib_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/eib_filter_unit.sv -----
`timescale 1ns / 1ps

module eib_filter_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  eib_pkg::seq_ctrl_t        ctrl,
    input  logic [4:0]                weight,
    input  logic [eib_pkg::PIX_W-1:0] rdata,
    output logic [eib_pkg::PIX_W-1:0] wdata
);

    logic [eib_pkg::ACC_W-1:0] acc0_reg, acc1_reg, acc2_reg;
    logic [eib_pkg::ACC_W-1:0] acc_sel;
    logic [7:0]                pix_sel;
    logic signed [12:0]        diff;
    logic signed [18:0]        prod;
    logic signed [18:0]        prod_adj;
    logic signed [14:0]        quot;
    logic [eib_pkg::ACC_W-1:0] acc_new;

    always_comb
    begin
        case (ctrl.ch)
            2'd1:
            begin
                acc_sel = acc1_reg;
                pix_sel = rdata[15:8];
            end
            2'd2:
            begin
                acc_sel = acc2_reg;
                pix_sel = rdata[23:16];
            end
            default:
            begin
                acc_sel = acc0_reg;
                pix_sel = rdata[7:0];
            end
        endcase
    end

    // shared update: acc += ((pix*16 - acc) * w) / 16, truncating toward zero
    always_comb
    begin
        diff     = $signed({1'b0, pix_sel, 4'b0000}) - $signed({1'b0, acc_sel});
        prod     = 19'(diff) * 19'($signed({1'b0, weight}));
        prod_adj = prod + (prod[18] ? 19'sd15 : 19'sd0);
        quot     = prod_adj[18:4];
        acc_new  = acc_sel + quot[eib_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc0_reg <= '0;
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        else if (ctrl.seed)
        begin
            acc0_reg <= {rdata[7:0], 4'b0000};
            acc1_reg <= {rdata[15:8], 4'b0000};
            acc2_reg <= {rdata[23:16], 4'b0000};
        end
        else if (ctrl.calc)
        begin
            case (ctrl.ch)
                2'd1:    acc1_reg <= acc_new;
                2'd2:    acc2_reg <= acc_new;
                default: acc0_reg <= acc_new;
            endcase
        end
    end

    assign wdata = {rdata[31:24], acc2_reg[11:4], acc1_reg[11:4], acc0_reg[11:4]};

endmodule

// ----- rtl/core/eib_sweep_seq.sv -----
`timescale 1ns / 1ps

module eib_sweep_seq #(
    parameter int MAX_WIDTH  = 256,
    parameter int AW         = 16,
    parameter int SW         = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SW-1:0]       cols,
    input  logic [SW-1:0]       rows,
    output eib_pkg::seq_ctrl_t  ctrl,
    output logic [AW-1:0]       addr
);

    localparam logic [2:0] Q_IDLE  = 3'd0;
    localparam logic [2:0] Q_READ  = 3'd1;
    localparam logic [2:0] Q_SEED  = 3'd2;
    localparam logic [2:0] Q_CALC  = 3'd3;
    localparam logic [2:0] Q_WRITE = 3'd4;
    localparam logic [2:0] Q_DONE  = 3'd5;

    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

    logic [2:0]    state_reg, state_next;
    logic [1:0]    pass_reg, pass_next;
    logic [SW-1:0] line_reg, line_next;
    logic [SW-1:0] k_reg, k_next;
    logic [1:0]    ch_reg, ch_next;

    logic          vertical, forward;
    logic [SW-1:0] count, nlines, pos, x, y;
    logic          advance;

    always_comb
    begin
        vertical = ~pass_reg[0];
        forward  = ~pass_reg[1];
        count    = vertical ? rows : cols;
        nlines   = vertical ? cols : rows;
        pos      = forward ? k_reg : (count - 1'b1 - k_reg);
        x        = vertical ? line_reg : pos;
        y        = vertical ? pos : line_reg;
        addr     = AW'(y) * ROW_STEP + AW'(x);
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        line_next  = line_reg;
        k_next     = k_reg;
        ch_next    = ch_reg;
        advance    = 1'b0;
        ctrl       = '0;
        ctrl.ch    = ch_reg;
        case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    pass_next  = 2'd0;
                    line_next  = '0;
                    k_next     = '0;
                    state_next = Q_READ;
                end
            end
            Q_READ:
            begin
                ctrl.mem_en = 1'b1;
                ch_next     = 2'd0;
                state_next  = (k_reg == '0) ? Q_SEED : Q_CALC;
            end
            Q_SEED:
            begin
                ctrl.seed = 1'b1;
                advance   = 1'b1;
            end
            Q_CALC:
            begin
                ctrl.calc = 1'b1;
                ch_next   = ch_reg + 2'd1;
                if (ch_reg == 2'd2)
                begin
                    state_next = Q_WRITE;
                end
            end
            Q_WRITE:
            begin
                ctrl.mem_en = 1'b1;
                ctrl.mem_we = 1'b1;
                advance     = 1'b1;
            end
            Q_DONE:
            begin
                ctrl.done  = 1'b1;
                state_next = Q_IDLE;
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase

        if (advance)
        begin
            state_next = Q_READ;
            if (k_reg != count - 1'b1)
            begin
                k_next = k_reg + 1'b1;
            end
            else
            begin
                k_next = '0;
                if (line_reg != nlines - 1'b1)
                begin
                    line_next = line_reg + 1'b1;
                end
                else
                begin
                    line_next = '0;
                    if (pass_reg != 2'd3)
                    begin
                        pass_next = pass_reg + 2'd1;
                    end
                    else
                    begin
                        state_next = Q_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            pass_reg  <= 2'd0;
            line_reg  <= '0;
            k_reg     <= '0;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            line_reg  <= line_next;
            k_reg     <= k_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

// ----- rtl/core/exponential_image_blur.sv -----
`timescale 1ns / 1ps
// pixel write: accepted while idle, next item can follow at once
// pixel read: result goes through the registered pixel ram read and then the output register;
// next item is taken once the read leaves its wait state, which lasts while an earlier result is unread
// blur run: read and seed for the first pixel of each line; read, three channel updates through
// the one shared update unit and write for every other pixel; four passes
// reset: control, output valid and registers clear (radius 0, size 256 x 256); pixel ram is not cleared
module exponential_image_blur #(
    parameter int MAX_WIDTH  = eib_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = eib_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x, pos_y, in_blue, in_green, in_red, in_alpha
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic        m_tuser,   // kind
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SW    = $clog2(MAXD + 1);
    localparam int CW    = (SW > 9) ? SW : 9;

    localparam logic [CW-1:0] MW_C = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MH_C = CW'(MAX_HEIGHT);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

    localparam logic [1:0] T_IDLE   = 2'd0;
    localparam logic [1:0] T_RDWAIT = 2'd1;
    localparam logic [1:0] T_BLUR   = 2'd2;
    localparam logic [1:0] T_DONE   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  radius_reg;
    logic [8:0]  width_reg, height_reg;
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [31:0] out_data_reg;
    logic        in_store_reg;

    logic        accept;
    logic        out_free;
    logic [7:0]  pos_x, pos_y;
    logic        in_store;
    logic [AW-1:0] in_addr;
    logic [CW-1:0] wext, hext, cols_c, rows_c;
    logic [SW-1:0] cols, rows;

    eib_pkg::seq_ctrl_t        seq_ctrl;
    logic [AW-1:0]             seq_addr;
    logic [eib_pkg::PIX_W-1:0] ram_rdata, filt_wdata;
    logic                      ram_en, ram_we;
    logic [AW-1:0]             ram_addr;
    logic [eib_pkg::PIX_W-1:0] ram_wdata;
    logic [4:0]                weight;

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign pos_x    = s_tdata[7:0];
    assign pos_y    = s_tdata[15:8];
    assign in_store = (13'(pos_x) < 13'(MAX_WIDTH)) && (13'(pos_y) < 13'(MAX_HEIGHT));
    assign in_addr  = AW'(pos_y) * ROW_STEP + AW'(pos_x);
    assign weight   = eib_pkg::pick_weight(radius_reg);

    always_comb
    begin
        wext   = CW'(width_reg);
        hext   = CW'(height_reg);
        cols_c = (wext == '0) ? CW'(1) : ((wext > MW_C) ? MW_C : wext);
        rows_c = (hext == '0) ? CW'(1) : ((hext > MH_C) ? MH_C : hext);
        cols   = cols_c[SW-1:0];
        rows   = rows_c[SW-1:0];
    end

    // the sweep owns the ram while a blur runs
    always_comb
    begin
        if (state_reg == T_BLUR)
        begin
            ram_en    = seq_ctrl.mem_en;
            ram_we    = seq_ctrl.mem_we;
            ram_addr  = seq_addr;
            ram_wdata = filt_wdata;
        end
        else
        begin
            ram_en    = accept && in_store &&
                        ((s_tuser == eib_pkg::CMD_WRITE) || (s_tuser == eib_pkg::CMD_READ));
            ram_we    = (s_tuser == eib_pkg::CMD_WRITE);
            ram_addr  = in_addr;
            ram_wdata = s_tdata[47:16];
        end
    end

    eib_pixel_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    eib_sweep_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .SW        (SW)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (s_tuser == eib_pkg::CMD_RUN)),
        .cols  (cols),
        .rows  (rows),
        .ctrl  (seq_ctrl),
        .addr  (seq_addr)
    );

    eib_filter_unit u_filt (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (seq_ctrl),
        .weight (weight),
        .rdata  (ram_rdata),
        .wdata  (filt_wdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept && (s_tuser == eib_pkg::CMD_READ))
                begin
                    state_next = T_RDWAIT;
                end
                else if (accept && (s_tuser == eib_pkg::CMD_RUN))
                begin
                    state_next = T_BLUR;
                end
            end
            // read data stays in the ram output register until the result slot frees
            T_RDWAIT:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            T_BLUR:
            begin
                if (seq_ctrl.done)
                begin
                    state_next = T_DONE;
                end
            end
            T_DONE:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            radius_reg    <= 5'd0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= eib_pkg::KIND_READ;
            in_store_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    eib_pkg::REG_RADIUS: radius_reg <= cfg_wdata[4:0];
                    eib_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                    eib_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                    default:             ;
                endcase
            end
            if (accept)
            begin
                in_store_reg <= in_store;
            end
            if ((state_reg == T_RDWAIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= eib_pkg::KIND_READ;
            end
            else if ((state_reg == T_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= eib_pkg::KIND_DONE;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == T_RDWAIT) && out_free)
        begin
            out_data_reg <= in_store_reg ? ram_rdata : 32'd0;
        end
        else if ((state_reg == T_DONE) && out_free)
        begin
            out_data_reg <= 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- tb/exponential_image_blur_test.sv -----
`timescale 1ns / 1ps

module exponential_image_blur_test;

    localparam int FRAME_W = eib_pkg::MAX_WIDTH_DEF;
    localparam int FRAME_H = eib_pkg::MAX_HEIGHT_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_GOAL = 2020;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic        kind;
        logic [31:0] pix;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // pos_x, pos_y, in_blue, in_green, in_red, in_alpha
    logic [1:0]  s_tuser = '0;    // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // out_blue, out_green, out_red, out_alpha
    logic        m_tuser;         // kind
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [8:0]  cfg_wdata = '0;

    // mirror of the pixel ram and which entries hold written data
    logic [31:0] frame_mem [FRAME_W * FRAME_H];
    bit          frame_set [FRAME_W * FRAME_H];
    logic [15:0] set_addrs [$];
    reply_t      queued_replies [$];

    logic [4:0]  cur_radius = 5'd0;
    logic [8:0]  cur_width = 9'd256;
    logic [8:0]  cur_height = 9'd256;

    string       chan_names [4] = '{"blue", "green", "red", "alpha"};

    int          burst_left = 0;
    int          items_done = 0;
    int          pixel_writes = 0;
    int          pixel_reads = 0;
    int          blur_runs = 0;
    int          replies_checked = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    int          rx_mode = 0;
    int          rx_left = 0;

    exponential_image_blur dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern, switching mode at random intervals
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 400);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= ((cycle_count % 16) < 4);
        endcase
    end

    always @(posedge clk)
    begin : check_port
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (queued_replies.size() == 0)
            begin
                $display("%0t: result with nothing expected: kind %0d data %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = queued_replies.pop_front();
                replies_checked++;
                if (m_tuser !== want.kind)
                begin
                    $display("%0t: kind mismatch: expected %0d, got %0d",
                             $time, want.kind, m_tuser);
                    mismatches++;
                end
                for (int c = 0; c < 4; c++)
                begin
                    if (m_tdata[8*c +: 8] !== want.pix[8*c +: 8])
                    begin
                        $display("%0t: %s mismatch: expected %h, got %h", $time,
                                 chan_names[c], want.pix[8*c +: 8], m_tdata[8*c +: 8]);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic int smoothing_weight(input logic [4:0] radius);
        if (radius == 5'd0) return 16;
        if (radius > 5'd17) return 1;
        if (radius >= 5'd12) return 2;
        if (radius >= 5'd8) return 3;
        case (radius)
            5'd1: return 14;
            5'd2: return 10;
            5'd3: return 8;
            5'd4: return 6;
            5'd7: return 4;
            default: return 5;
        endcase
    endfunction

    function automatic int span_of(input logic [8:0] v, input int cap);
        if (v == 9'd0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    // one recursive pass over count pixels, starting at base
    function automatic void smooth_line(input int base, input int stride, input int count,
                                        input int wgt);
        int acc [3];
        int k;
        int idx;
        int target;
        for (int c = 0; c < 3; c++)
            acc[c] = int'(frame_mem[base][8*c +: 8]) * 16;
        for (k = 1; k < count; k++)
        begin
            idx = base + k * stride;
            for (int c = 0; c < 3; c++)
            begin
                target = int'(frame_mem[idx][8*c +: 8]) * 16;
                acc[c] += ((target - acc[c]) * wgt) / 16;
                frame_mem[idx][8*c +: 8] = 8'(acc[c] >>> 4);
            end
        end
    endfunction

    function automatic void blur_frame();
        int wgt;
        int cols;
        int rows;
        wgt = smoothing_weight(cur_radius);
        cols = span_of(cur_width, FRAME_W);
        rows = span_of(cur_height, FRAME_H);
        for (int i = 0; i < cols; i++)
            smooth_line(i, FRAME_W, rows, wgt);
        for (int i = 0; i < rows; i++)
            smooth_line(i * FRAME_W, 1, cols, wgt);
        for (int i = 0; i < cols; i++)
            smooth_line((rows - 1) * FRAME_W + i, -FRAME_W, rows, wgt);
        for (int i = 0; i < rows; i++)
            smooth_line(i * FRAME_W + cols - 1, -1, cols, wgt);
    endfunction

    function automatic void apply_item(input logic [1:0] cmd, input logic [7:0] x,
                                       input logic [7:0] y, input logic [31:0] pix);
        reply_t r;
        case (cmd)
            eib_pkg::CMD_WRITE:
            begin
                frame_mem[{y, x}] = pix;
                if (!frame_set[{y, x}])
                begin
                    frame_set[{y, x}] = 1'b1;
                    set_addrs.push_back({y, x});
                end
                pixel_writes++;
            end
            eib_pkg::CMD_RUN:
            begin
                blur_frame();
                r.kind = eib_pkg::KIND_DONE;
                r.pix = '0;
                queued_replies.push_back(r);
                blur_runs++;
            end
            eib_pkg::CMD_READ:
            begin
                r.kind = eib_pkg::KIND_READ;
                r.pix = frame_mem[{y, x}];
                queued_replies.push_back(r);
                pixel_reads++;
            end
            default: ;
        endcase
        if (cmd != CMD_UNUSED)
            items_done++;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] x, input logic [7:0] y,
                             input logic [31:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {pix[31:24], pix[23:16], pix[15:8], pix[7:0], y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_item(cmd, x, y, pix);
    endtask

    // sender holds off until every owed result is back, optionally letting writes settle
    task automatic wait_for_replies(input int settle);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (queued_replies.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic program_regs(input logic [4:0] radius, input logic [8:0] width,
                                input logic [8:0] height);
        wait_for_replies(8);
        cfg_we <= 1'b1;
        cfg_addr <= eib_pkg::REG_RADIUS;
        cfg_wdata <= {4'd0, radius};
        @(posedge clk);
        cfg_addr <= eib_pkg::REG_WIDTH;
        cfg_wdata <= width;
        @(posedge clk);
        cfg_addr <= eib_pkg::REG_HEIGHT;
        cfg_wdata <= height;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_radius = radius;
        cur_width = width;
        cur_height = height;
    endtask

    // mode 0 fills only unwritten pixels, 1 rewrites randomly, 2 rewrites a checkerboard
    task automatic fill_region(input int mode);
        int cols;
        int rows;
        logic [31:0] pix;
        cols = span_of(cur_width, FRAME_W);
        rows = span_of(cur_height, FRAME_H);
        for (int yy = 0; yy < rows; yy++)
        begin
            for (int xx = 0; xx < cols; xx++)
            begin
                if (mode == 0 && frame_set[yy * FRAME_W + xx])
                    continue;
                if (mode == 2)
                    pix = ((xx + yy) % 2 == 1) ? 32'hFFFF_FFFF : {8'($urandom()), 24'd0};
                else
                    pix = $urandom();
                send_item(eib_pkg::CMD_WRITE, 8'(xx), 8'(yy), pix);
            end
        end
    endtask

    function automatic logic [7:0] pick_coord(input int span);
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2, 3, 4, 5: return 8'($urandom_range(0, span - 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic read_random_pixel();
        logic [15:0] addr;
        addr = set_addrs[$urandom_range(0, set_addrs.size() - 1)];
        send_item(eib_pkg::CMD_READ, addr[7:0], addr[15:8], $urandom());
    endtask

    task automatic test_corner_pixels();
        send_item(eib_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h0000_0000);
        send_item(eib_pkg::CMD_WRITE, 8'd255, 8'd0, 32'hFFFF_FFFF);
        send_item(eib_pkg::CMD_WRITE, 8'd0, 8'd255, 32'h00FF_00FF);
        send_item(eib_pkg::CMD_WRITE, 8'd255, 8'd255, 32'hFF00_FF00);
        send_item(eib_pkg::CMD_READ, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(eib_pkg::CMD_READ, 8'd255, 8'd0, 32'h0);
        send_item(eib_pkg::CMD_READ, 8'd0, 8'd255, 32'h0);
        send_item(eib_pkg::CMD_READ, 8'd255, 8'd255, 32'h0);
    endtask

    task automatic test_unused_command();
        send_item(CMD_UNUSED, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(eib_pkg::CMD_READ, 8'd0, 8'd0, 32'h0);
    endtask

    // zero sizes act as a single pixel, which the blur leaves as it is
    task automatic test_degenerate_size();
        program_regs(5'd31, 9'd0, 9'd0);
        send_item(eib_pkg::CMD_RUN, 8'd0, 8'd0, 32'h0);
        send_item(eib_pkg::CMD_READ, 8'd0, 8'd0, 32'h0);
    endtask

    task automatic test_small_blur();
        program_regs(5'd1, 9'd3, 9'd2);
        fill_region(2);
        send_item(eib_pkg::CMD_RUN, 8'd0, 8'd0, 32'h0);
        send_item(eib_pkg::CMD_READ, 8'd2, 8'd1, 32'h0);
        send_item(eib_pkg::CMD_READ, 8'd0, 8'd0, 32'h0);
        send_item(eib_pkg::CMD_READ, 8'd255, 8'd255, 32'h0);
    endtask

    task automatic test_random_frames();
        int phase;
        int n_ops;
        int pick;
        int cols;
        int rows;
        logic [4:0] radius;
        logic [8:0] width;
        logic [8:0] height;
        phase = 0;
        while (items_done < RANDOM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    width = ($urandom_range(0, 1) == 0) ? 9'd256 : 9'($urandom_range(257, 511));
                    height = 9'($urandom_range(0, 2));
                end
                1:
                begin
                    height = ($urandom_range(0, 1) == 0) ? 9'd256 : 9'($urandom_range(257, 511));
                    width = 9'($urandom_range(0, 2));
                end
                2:
                begin
                    width = 9'($urandom_range(0, 2));
                    height = 9'($urandom_range(0, 2));
                end
                default:
                begin
                    width = 9'($urandom_range(1, 16));
                    height = 9'($urandom_range(1, 16));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: radius = 5'd0;
                    1: radius = 5'd1;
                    2: radius = 5'd17;
                    3: radius = 5'd18;
                    default: radius = 5'd31;
                endcase
            end
            else
            begin
                radius = 5'($urandom_range(0, 31));
            end
            program_regs(radius, width, height);
            cols = span_of(cur_width, FRAME_W);
            rows = span_of(cur_height, FRAME_H);
            fill_region($urandom_range(0, 2));

            n_ops = $urandom_range(15, 50);
            for (int k = 0; k < n_ops; k++)
            begin
                if (phase % 3 == 0 && k == n_ops / 2)
                    wait_for_replies(0);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_item(eib_pkg::CMD_WRITE, pick_coord(cols), pick_coord(rows),
                              $urandom());
                else if (pick < 87)
                    read_random_pixel();
                else if (pick < 93)
                    send_item(eib_pkg::CMD_RUN, 8'($urandom()), 8'($urandom()), $urandom());
                else
                    send_item(CMD_UNUSED, 8'($urandom()), 8'($urandom()), $urandom());
            end

            send_item(eib_pkg::CMD_RUN, 8'($urandom()), 8'($urandom()), $urandom());
            repeat ($urandom_range(2, 6))
                send_item(eib_pkg::CMD_READ, 8'($urandom_range(0, cols - 1)),
                          8'($urandom_range(0, rows - 1)), $urandom());
            phase++;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_unused_command();
        test_degenerate_size();
        test_small_blur();
        test_random_frames();

        wait_for_replies(50);
        $display("run covered %0d pixel writes, %0d reads and %0d blur runs; %0d results checked",
                 pixel_writes, pixel_reads, blur_runs, replies_checked);
        $display("regions from one pixel to full-length lines, radii 0 to 31, size values 0 to 511");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
